// File: hdl/vrrb_pkg.sv
// Shared constants, codes and ring arithmetic for the variable record ring buffer.
`default_nettype none

package vrrb_pkg;

    localparam int CAPACITY     = 1024;
    localparam int HEADER_BYTES = 2;

    // Field widths of the item and result beats
    localparam int ACTION_W = 2;
    localparam int LEN_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 10;
    localparam int STATUS_W = 3;
    localparam int FIRST_W  = 10;
    localparam int COUNT_W  = 10;
    localparam int FREE_W   = 11;

    // Internal widths
    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int USED_W = $clog2(CAPACITY + 1);
    localparam int REC_W  = $clog2(CAPACITY / HEADER_BYTES + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int HDR_W  = 8 * HEADER_BYTES;
    localparam int IDX_W  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int NEED_W = ((USED_W > LEN_W + 1) ? USED_W : LEN_W + 1) + 1;

    localparam logic [63:0]      HDR_LIMIT = (64'd1 << HDR_W) - 64'd1;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(HEADER_BYTES - 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_ERASE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_OFFSET    = 3'd3,
        ST_SURPLUS   = 3'd4
    } status_t;

    // p + k modulo CAPACITY; k never exceeds CAPACITY where it matters
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                  input logic [SUM_W-1:0] k);
        logic [SUM_W:0] s;
        s = (SUM_W + 1)'(p) + (SUM_W + 1)'(k);
        if (s >= (SUM_W + 1)'(CAPACITY))
        begin
            s = s - (SUM_W + 1)'(CAPACITY);
        end
        return PTR_W'(s);
    endfunction

endpackage

`default_nettype wire

// File: hdl/vrrb_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module vrrb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/variable_record_ring_buffer_drop_oldest_core.sv
// Length-prefixed record ring with drop-oldest overwrite: control and byte store.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | action, record_length, data_byte, byte_offset
//  out     | out_valid / out_ready| status, read_byte, oldest_length, record_count,
//          |                      | free_bytes
//
// Append: back to back while out_ready keeps up. Read: registered RAM read (S_RDWAIT). Erase:
// at once, or S_HADDR/S_HDATA per byte when the next oldest header is fetched from RAM.
// Begin: S_FLUSH pads the bytes still due, then S_DROP and S_HADDR/S_HDATA per dropped record,
// S_DROP alone for a dropped record that is the last one held, then S_HWRITE per header byte;
// the single RAM write port and single read port set this sequencing.
// Reset clears pointers, counters and the registered outputs; the byte store is not cleared.
// A result beat held by out_ready low blocks the next input beat.
`default_nettype none

module variable_record_ring_buffer_drop_oldest_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [vrrb_pkg::ACTION_W-1:0] action,
    input  logic [vrrb_pkg::LEN_W-1:0]    record_length,
    input  logic [vrrb_pkg::BYTE_W-1:0]   data_byte,
    input  logic [vrrb_pkg::OFFSET_W-1:0] byte_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vrrb_pkg::STATUS_W-1:0] status,
    output logic [vrrb_pkg::BYTE_W-1:0]   read_byte,
    output logic [vrrb_pkg::FIRST_W-1:0]  oldest_length,
    output logic [vrrb_pkg::COUNT_W-1:0]  record_count,
    output logic [vrrb_pkg::FREE_W-1:0]   free_bytes
);

    import vrrb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_FLUSH,
        S_DROP,
        S_HADDR,
        S_HDATA,
        S_HWRITE
    } state_t;

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [REC_W-1:0]    rec_reg, rec_next;
    logic [LEN_W-1:0]    due_reg, due_next;
    logic [LEN_W-1:0]    first_reg, first_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    action_t             op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [HDR_W-1:0]    hdr_reg, hdr_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;
    logic [FIRST_W-1:0]  out_first_reg, out_first_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [FREE_W-1:0]   out_free_reg, out_free_next;

    logic                accept;
    logic                load_out;
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [PTR_W-1:0]    ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    // Removal of the oldest record: its header plus data
    logic [SUM_W-1:0]    drop_total;
    logic [PTR_W-1:0]    drop_rp;
    logic [USED_W-1:0]   drop_used;
    logic [USED_W-1:0]   free_now;
    logic                too_large;
    logic [LEN_W-1:0]    avail;

    assign in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign drop_total = SUM_W'(HEADER_BYTES) + SUM_W'(first_reg);
    assign drop_rp    = ring_add(rp_reg, drop_total);
    assign drop_used  = (used_reg >= USED_W'(drop_total)) ? used_reg - USED_W'(drop_total)
                                                          : '0;
    assign free_now   = USED_W'(CAPACITY) - used_reg;
    assign too_large  = ((LEN_W + 4)'(record_length) + (LEN_W + 4)'(HEADER_BYTES)
                         > (LEN_W + 4)'(CAPACITY))
                        || (64'(record_length) > HDR_LIMIT);
    assign avail      = (rec_reg == REC_W'(1)) ? first_reg - due_reg : first_reg;

    vrrb_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (BYTE_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        used_next  = used_reg;
        rec_next   = rec_reg;
        due_next   = due_reg;
        first_next = first_reg;
        len_next   = len_reg;
        need_next  = need_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        hdr_next   = hdr_reg;
        status_next = status_reg;
        rbyte_next = '0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = rp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_t'(action))
                        ACT_BEGIN:
                        begin
                            len_next  = record_length;
                            need_next = NEED_W'(HEADER_BYTES) + NEED_W'(record_length);
                            op_next   = ACT_BEGIN;
                            if (too_large)
                            begin
                                status_next = ST_TOO_LARGE;
                                load_out    = 1'b1;
                            end
                            else if (due_reg != '0)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                state_next = S_DROP;
                            end
                        end
                        ACT_DATA:
                        begin
                            load_out = 1'b1;
                            if (due_reg == '0)
                            begin
                                status_next = ST_SURPLUS;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                ram_we      = 1'b1;
                                ram_wdata   = data_byte;
                                wp_next     = ring_add(wp_reg, SUM_W'(1));
                                due_next    = due_reg - LEN_W'(1);
                            end
                        end
                        ACT_READ:
                        begin
                            if (rec_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                load_out    = 1'b1;
                            end
                            else if (byte_offset >= avail)
                            begin
                                status_next = ST_OFFSET;
                                load_out    = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ring_add(rp_reg, SUM_W'(HEADER_BYTES)
                                                              + SUM_W'(byte_offset));
                                state_next = S_RDWAIT;
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (rec_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                load_out    = 1'b1;
                            end
                            else if (rec_reg == REC_W'(1))
                            begin
                                // last record goes, finished or not
                                status_next = ST_OK;
                                load_out    = 1'b1;
                                rp_next     = wp_reg;
                                used_next   = '0;
                                rec_next    = '0;
                                due_next    = '0;
                                first_next  = '0;
                            end
                            else
                            begin
                                rp_next    = drop_rp;
                                used_next  = drop_used;
                                rec_next   = rec_reg - REC_W'(1);
                                op_next    = ACT_ERASE;
                                idx_next   = '0;
                                state_next = S_HADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                status_next = ST_OK;
                rbyte_next  = ram_rdata;
                load_out    = 1'b1;
                state_next  = S_IDLE;
            end
            S_FLUSH:
            begin
                // pad the unfinished record with zero bytes
                ram_we   = 1'b1;
                wp_next  = ring_add(wp_reg, SUM_W'(1));
                due_next = due_reg - LEN_W'(1);
                if (due_reg == LEN_W'(1))
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:
            begin
                if ((NEED_W'(free_now) < need_reg) && (rec_reg != '0))
                begin
                    rec_next = rec_reg - REC_W'(1);
                    if (rec_reg == REC_W'(1))
                    begin
                        rp_next    = wp_reg;
                        used_next  = '0;
                        first_next = '0;
                    end
                    else
                    begin
                        rp_next    = drop_rp;
                        used_next  = drop_used;
                        idx_next   = '0;
                        state_next = S_HADDR;
                    end
                end
                else
                begin
                    if (rec_reg == '0)
                    begin
                        rp_next   = wp_reg;
                        used_next = '0;
                    end
                    idx_next   = '0;
                    state_next = S_HWRITE;
                end
            end
            S_HADDR:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ring_add(rp_reg, SUM_W'(idx_reg));
                state_next = S_HDATA;
            end
            S_HDATA:
            begin
                hdr_next[8 * idx_reg +: 8] = ram_rdata;
                if (idx_reg == IDX_LAST)
                begin
                    first_next = LEN_W'(hdr_next);
                    if (op_reg == ACT_ERASE)
                    begin
                        status_next = ST_OK;
                        load_out    = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DROP;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_HADDR;
                end
            end
            S_HWRITE:
            begin
                // header goes out little-endian
                ram_we    = 1'b1;
                ram_wdata = BYTE_W'(len_reg >> (8 * idx_reg));
                wp_next   = ring_add(wp_reg, SUM_W'(1));
                if (idx_reg == IDX_LAST)
                begin
                    used_next   = used_reg + USED_W'(need_reg);
                    rec_next    = rec_reg + REC_W'(1);
                    due_next    = len_reg;
                    if (rec_reg == '0)
                    begin
                        first_next = len_reg;
                    end
                    status_next = ST_OK;
                    load_out    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_first_next = out_first_reg;
        out_count_next = out_count_reg;
        out_free_next  = out_free_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_first_next = FIRST_W'(first_next);
            out_count_next = COUNT_W'(rec_next);
            out_free_next  = FREE_W'(USED_W'(CAPACITY) - used_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            used_reg      <= '0;
            rec_reg       <= '0;
            due_reg       <= '0;
            first_reg     <= '0;
            len_reg       <= '0;
            need_reg      <= '0;
            op_reg        <= ACT_BEGIN;
            idx_reg       <= '0;
            hdr_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            rbyte_reg     <= '0;
            out_first_reg <= '0;
            out_count_reg <= '0;
            out_free_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            used_reg      <= used_next;
            rec_reg       <= rec_next;
            due_reg       <= due_next;
            first_reg     <= first_next;
            len_reg       <= len_next;
            need_reg      <= need_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            hdr_reg       <= hdr_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                status_reg <= status_next;
                rbyte_reg  <= rbyte_next;
            end
            out_first_reg <= out_first_next;
            out_count_reg <= out_count_next;
            out_free_reg  <= out_free_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_byte     = rbyte_reg;
    assign oldest_length = out_first_reg;
    assign record_count  = out_count_reg;
    assign free_bytes    = out_free_reg;

`ifndef ASSERT_OFF
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rec_reg == '0 |-> used_reg == '0 && first_reg == '0 && due_reg == '0)
        else $error("empty ring with bytes, length or dues left");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(CAPACITY))
        else $error("used bytes beyond capacity");

    a_oldest_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && rec_reg != '0
        |-> (USED_W + 1)'(first_reg) + (USED_W + 1)'(HEADER_BYTES)
            <= (USED_W + 1)'(used_reg))
        else $error("oldest record larger than bytes in use");

    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDWAIT |=> out_valid_reg && state_reg == S_IDLE)
        else $error("read beat not produced after RAM latency");
`endif

endmodule

`default_nettype wire
